@@ rtl/csnd_pkg.sv @@
// Shared types, constants and codes for the chunked ARQ sender core.
package csnd_pkg;

  // Default geometry of the message split
  localparam int MAX_CHUNKS_DEF  = 32;
  localparam int CHUNK_BYTES_DEF = 20;

  // Fixed field widths
  localparam int SEQ_W   = 6;
  localparam int LEN_W   = 10;
  localparam int COUNT_W = 5;

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_MESSAGE_LENGTH = 1'b0;

  // Event opcodes
  localparam logic [1:0] OP_START   = 2'd0;
  localparam logic [1:0] OP_ACK     = 2'd1;
  localparam logic [1:0] OP_TIMEOUT = 2'd2;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [SEQ_W-1:0] ack_seq;
  } in_item_t;

  typedef struct packed {
    logic [SEQ_W-1:0]   chunk_seq;
    logic [LEN_W-1:0]   byte_offset;
    logic [COUNT_W-1:0] byte_count;
    logic               done_frame;
    logic               is_resend;
    logic               last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_RESEND,
    ST_NEXT,
    ST_SCAN,
    ST_SEND,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    EMIT_RESEND,
    EMIT_CHUNK,
    EMIT_DONE
  } emit_kind_t;

  // Controller to datapath
  typedef struct packed {
    logic       take_event;
    logic       start_xfer;
    logic       mark_ack;
    logic       ptr_reset;
    logic       ptr_inc;
    logic       next_from_ptr;
    logic       next_inc;
    logic       go_idle;
    logic       emit;
    emit_kind_t kind;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [1:0] opcode;
    logic       active;
    logic       ack_in_range;
    logic       ptr_past;
    logic       ptr_acked;
    logic       next_scan;
    logic       out_free;
  } dp_status_t;

endpackage

@@ rtl/csnd_ctrl.sv @@
// Controller state machine of the chunked ARQ sender core.
module csnd_ctrl
  import csnd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.kind   = EMIT_CHUNK;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take_event = 1'b1;
          state_next     = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (status.opcode == OP_START) begin
          cmd.start_xfer = 1'b1;
          state_next     = ST_NEXT;
        end else if (status.opcode == OP_ACK && status.active) begin
          cmd.mark_ack = status.ack_in_range;
          state_next   = ST_NEXT;
        end else if (status.opcode == OP_TIMEOUT && status.active) begin
          cmd.ptr_reset = 1'b1;
          state_next    = ST_RESEND;
        end else begin
          // idle-time ack/timeout and the unused code give no transfer
          state_next = ST_IDLE;
        end
      end
      ST_RESEND: begin
        if (status.ptr_past) begin
          state_next = ST_NEXT;
        end else if (status.ptr_acked) begin
          cmd.ptr_inc = 1'b1;
        end else if (status.out_free) begin
          cmd.emit    = 1'b1;
          cmd.kind    = EMIT_RESEND;
          cmd.ptr_inc = 1'b1;
        end
      end
      ST_NEXT: begin
        if (status.next_scan) begin
          cmd.ptr_reset = 1'b1;
          state_next    = ST_SCAN;
        end else begin
          state_next = ST_SEND;
        end
      end
      ST_SCAN: begin
        if (status.ptr_past) begin
          state_next = ST_DONE;
        end else if (status.ptr_acked) begin
          cmd.ptr_inc = 1'b1;
        end else begin
          cmd.next_from_ptr = 1'b1;
          state_next        = ST_SEND;
        end
      end
      ST_SEND: begin
        if (status.out_free) begin
          cmd.emit     = 1'b1;
          cmd.kind     = EMIT_CHUNK;
          cmd.next_inc = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.emit    = 1'b1;
          cmd.kind    = EMIT_DONE;
          cmd.go_idle = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/csnd_datapath.sv @@
// Datapath of the chunked ARQ sender core: registers, bitmap, descriptor build.
module csnd_datapath
  import csnd_pkg::*;
#(
  parameter int MAX_CHUNKS  = MAX_CHUNKS_DEF,
  parameter int CHUNK_BYTES = CHUNK_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_data,
  input  ctrl_cmd_t          cmd,
  output dp_status_t         status
);

  localparam int MAP_IW      = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int PTR_W       = SEQ_W + 1;
  localparam int CW          = $clog2(CHUNK_BYTES + 1);
  localparam int OFF_W       = SEQ_W + CW;
  localparam int CMP_W       = (OFF_W > LEN_W) ? OFF_W : LEN_W;
  localparam int RSH         = 20;
  localparam int RECIP_W     = RSH + 1;
  localparam int PROD_W      = LEN_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((2 ** RSH) + CHUNK_BYTES - 1) / CHUNK_BYTES);
  localparam logic [CW-1:0]      CHUNK_C = CW'(CHUNK_BYTES);
  localparam logic [LEN_W:0]     MAX_C   = (LEN_W + 1)'(MAX_CHUNKS);

  logic [LEN_W-1:0]      message_length;
  logic [SEQ_W-1:0]      chunk_total;
  logic [MAX_CHUNKS-1:0] acked_map;
  logic [SEQ_W-1:0]      next_seq;
  logic                  active;
  logic [PTR_W-1:0]      ptr;
  logic [1:0]            ev_opcode;
  logic [SEQ_W-1:0]      ev_ack;

  // Configuration write and read-back
  always_ff @(posedge clk) begin
    if (rst) begin
      message_length <= '0;
    end else if (psel && penable && pwrite && paddr[2] == REG_MESSAGE_LENGTH) begin
      message_length <= pwdata[LEN_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_MESSAGE_LENGTH) ?
                  PDATA_W'(message_length) : '0;

  // Chunk count: length over chunk size by reciprocal, plus one, saturated
  logic [PROD_W-1:0] quot_prod;
  logic [LEN_W:0]    total_raw;

  assign quot_prod = PROD_W'(message_length) * PROD_W'(RECIP);
  assign total_raw = (LEN_W + 1)'(quot_prod[RSH +: LEN_W]) + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_total <= SEQ_W'(1);
    end else begin
      chunk_total <= (total_raw > MAX_C) ? SEQ_W'(MAX_CHUNKS) : total_raw[SEQ_W-1:0];
    end
  end

  // Latched event
  always_ff @(posedge clk) begin
    if (cmd.take_event) begin
      ev_opcode <= in_data.opcode;
      ev_ack    <= in_data.ack_seq;
    end
  end

  // Transfer state: bitmap, next sequence, active flag
  logic [MAP_IW-1:0] ack_idx;
  logic [MAP_IW-1:0] ptr_idx;

  assign ack_idx = MAP_IW'(ev_ack - 1'b1);
  assign ptr_idx = MAP_IW'(ptr - 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      acked_map <= '0;
      next_seq  <= SEQ_W'(1);
      active    <= 1'b0;
    end else begin
      if (cmd.start_xfer) begin
        acked_map <= '0;
        next_seq  <= SEQ_W'(1);
        active    <= 1'b1;
      end
      if (cmd.mark_ack) begin
        acked_map[ack_idx] <= 1'b1;
      end
      if (cmd.next_from_ptr) begin
        next_seq <= ptr[SEQ_W-1:0];
      end
      if (cmd.next_inc) begin
        next_seq <= next_seq + 1'b1;
      end
      if (cmd.go_idle) begin
        active <= 1'b0;
      end
    end
  end

  // Scan pointer, one chunk a cycle, held while a resend waits on a stalled output
  always_ff @(posedge clk) begin
    if (cmd.ptr_reset) begin
      ptr <= PTR_W'(1);
    end else if (cmd.ptr_inc) begin
      ptr <= ptr + 1'b1;
    end
  end

  // Status to the controller
  always_comb begin
    status.opcode       = ev_opcode;
    status.active       = active;
    status.ack_in_range = (ev_ack != '0) && (ev_ack <= chunk_total);
    status.ptr_past     = ptr > PTR_W'(chunk_total);
    status.ptr_acked    = acked_map[ptr_idx];
    status.next_scan    = (next_seq == '0) || (next_seq > chunk_total);
    status.out_free     = !out_valid || out_ready;
  end

  // Descriptor of the chunk at the selected sequence
  logic [SEQ_W-1:0] seq_sel;
  logic [OFF_W-1:0] offset;
  logic [CMP_W-1:0] remain;
  logic [CMP_W-1:0] count_full;

  assign seq_sel = (cmd.kind == EMIT_RESEND) ? ptr[SEQ_W-1:0] : next_seq;
  assign offset  = OFF_W'(seq_sel - 1'b1) * OFF_W'(CHUNK_C);

  always_comb begin
    remain = CMP_W'(message_length) - CMP_W'(offset);
    if (CMP_W'(message_length) > CMP_W'(offset)) begin
      count_full = (remain > CMP_W'(CHUNK_C)) ? CMP_W'(CHUNK_C) : remain;
    end else begin
      count_full = '0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.chunk_seq <= seq_sel;
      out_data.is_resend <= (cmd.kind == EMIT_RESEND);
      out_data.last      <= (cmd.kind != EMIT_RESEND);
      if (cmd.kind == EMIT_DONE) begin
        out_data.byte_offset <= '0;
        out_data.byte_count  <= '0;
        out_data.done_frame  <= 1'b1;
      end else begin
        out_data.byte_offset <= offset[LEN_W-1:0];
        out_data.byte_count  <= count_full[COUNT_W-1:0];
        out_data.done_frame  <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/chunked_arq_sender_core.sv @@
// Top level of the chunked ARQ sender core: controller, datapath, checks.
//
//  channel   direction  handshake                 payload
//  in        input      in_valid / in_ready       in_data   (opcode, ack_seq)
//  out       output     out_valid / out_ready     out_data  (descriptor)
//  cfg       input      psel/penable/pwrite       paddr, pwdata -> prdata
//
// An ack or start event passes through accept, decode, next-chunk check and
// send; a rewind adds a bitmap scan, which ends in a done frame if all are acked.
// A timeout walks every chunk up to the chunk count, one per cycle, emitting
// a resend for each unacknowledged one, then does the same as an ack.
// Reset (rst, synchronous) clears the bitmap, sets the next sequence to one
// and leaves the sender idle. A stalled output holds the walk in place.
module chunked_arq_sender_core
  import csnd_pkg::*;
#(
  parameter int MAX_CHUNKS  = MAX_CHUNKS_DEF,
  parameter int CHUNK_BYTES = CHUNK_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  assign pready = 1'b1;

  csnd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  csnd_datapath #(
    .MAX_CHUNKS  (MAX_CHUNKS),
    .CHUNK_BYTES (CHUNK_BYTES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .status    (status)
  );

`ifndef SYNTHESIS
  // An accepted event is worked on before another is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while previous event still in progress");

  // Done frame is empty and closes the event
  a_done_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.done_frame |->
      out_data.last && !out_data.is_resend && out_data.byte_count == '0)
    else $error("malformed done frame");

  // Resends never close the event
  a_resend_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.is_resend |-> !out_data.last)
    else $error("resend marked as final transfer of event");
`endif

endmodule
